FILE: sv/esc_pkg.sv
package esc_pkg;

   localparam int NUM_CH = 3;

   localparam logic [2:0] REQ_TICK  = 3'd0;
   localparam logic [2:0] REQ_SPEED = 3'd1;
   localparam logic [2:0] REQ_PULSE = 3'd2;
   localparam logic [2:0] REQ_STOP  = 3'd3;
   localparam logic [2:0] REQ_ESTOP = 3'd4;
   localparam logic [2:0] REQ_INIT  = 3'd5;

   localparam logic [1:0] CH_LEFT   = 2'd0;
   localparam logic [1:0] CH_RIGHT  = 2'd1;
   localparam logic [1:0] CH_WEAPON = 2'd2;
   localparam logic [1:0] CH_NONE   = 2'd3;

   typedef struct packed {
      logic [2:0]        req_type;
      logic [1:0]        channel;
      logic signed [7:0] speed;
      logic [15:0]       pulse_width;
      logic              armed;
      logic              failsafe;
   } req_item_type;

   typedef struct packed {
      logic        ok;
      logic        enabled;
      logic [15:0] left_pulse;
      logic [15:0] right_pulse;
      logic [15:0] weapon_pulse;
      logic [15:0] left_level;
      logic [15:0] right_level;
      logic [15:0] weapon_level;
   } rsp_item_type;

   // per-item state snapshot handed to the level stages
   typedef struct packed {
      logic                     ok;
      logic                     enabled;
      logic [NUM_CH-1:0][15:0]  pulse;
      logic [NUM_CH-1:0][15:0]  width;
   } snap_type;

   // level = width * wrap / 20000, saturated to 16 bits
   localparam longint      LEVEL_DIV   = 20000;
   localparam logic [32:0] LEVEL_SAT   = 33'(64'd65536 * LEVEL_DIV);
   // floor(x / 20000) = floor((x >> 5) / 625), reciprocal of 625 at 2^36
   localparam int          LEVEL_PRE   = 5;
   localparam int          LEVEL_SHIFT = 36;
   localparam logic [26:0] LEVEL_RECIP = 27'd109951163;

endpackage

FILE: sv/esc_level_pipe.sv
module esc_level_pipe (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  esc_pkg::snap_type    in_snap,
   input  logic [16:0]          wrap,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output esc_pkg::rsp_item_type rsp_item
);
   import esc_pkg::*;

   logic                       a_v_ff;
   logic                       a_ok_ff;
   logic                       a_en_ff;
   logic [NUM_CH-1:0][15:0]    a_pulse_ff;
   logic [NUM_CH-1:0][32:0]    a_prod_ff;
   logic [NUM_CH-1:0][32:0]    a_prod_in;
   logic                       o_v_ff;
   rsp_item_type               rsp_item_ff;
   rsp_item_type               rsp_item_in;
   logic [NUM_CH-1:0][15:0]    level;
   logic [NUM_CH-1:0][52:0]    quot_full;
   logic                       adv_a;
   logic                       adv_o;

   assign adv_o    = !o_v_ff || !rsp_stall;
   assign adv_a    = !a_v_ff || adv_o;
   assign in_stall = !adv_a;

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         a_prod_in[c] = in_snap.width[c] * wrap;
         quot_full[c] = a_prod_ff[c][30:LEVEL_PRE] * LEVEL_RECIP;
         if (a_prod_ff[c] >= LEVEL_SAT) begin
            level[c] = 16'hFFFF;
         end else begin
            level[c] = quot_full[c][LEVEL_SHIFT +: 16];
         end
      end
      rsp_item_in.ok           = a_ok_ff;
      rsp_item_in.enabled      = a_en_ff;
      rsp_item_in.left_pulse   = a_pulse_ff[CH_LEFT];
      rsp_item_in.right_pulse  = a_pulse_ff[CH_RIGHT];
      rsp_item_in.weapon_pulse = a_pulse_ff[CH_WEAPON];
      rsp_item_in.left_level   = level[CH_LEFT];
      rsp_item_in.right_level  = level[CH_RIGHT];
      rsp_item_in.weapon_level = level[CH_WEAPON];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else begin
         if (adv_a) begin
            a_v_ff <= in_valid;
         end
         if (adv_o) begin
            o_v_ff <= a_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && adv_a) begin
         a_ok_ff    <= in_snap.ok;
         a_en_ff    <= in_snap.enabled;
         a_pulse_ff <= in_snap.pulse;
         a_prod_ff  <= a_prod_in;
      end
      if (a_v_ff && adv_o) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = o_v_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

FILE: sv/esc_pulse_slew_controller.sv
// Slew-limited pulse widths for three RC pulse channels (left drive, right
// drive, weapon). One item is taken per clock while req_stall is low, and each
// accepted item gives exactly one result; a stalled result does not stop
// intake until all four pipeline registers are full. The path is: input
// register (speed times span), state update (percent scaling, clamps, slew),
// width times wrap, then scaling by 1/20000 with saturation. Registers sit on
// an APB port at byte address 4*index: min_width, neutral_pulse, max_pulse,
// pwm_wrap, slew_step, reverse_mask; write them only while no item is in
// flight.
module esc_pulse_slew_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  esc_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output esc_pkg::rsp_item_type rsp_item,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [4:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   import esc_pkg::*;

   localparam logic [2:0] CSR_MIN     = 3'd0;
   localparam logic [2:0] CSR_NEUTRAL = 3'd1;
   localparam logic [2:0] CSR_MAX     = 3'd2;
   localparam logic [2:0] CSR_WRAP    = 3'd3;
   localparam logic [2:0] CSR_STEP    = 3'd4;
   localparam logic [2:0] CSR_REVERSE = 3'd5;

   localparam logic [14:0] MIN_RST     = 15'd1000;
   localparam logic [14:0] NEUTRAL_RST = 15'd1500;
   localparam logic [14:0] MAX_RST     = 15'd2000;
   localparam logic [16:0] WRAP_RST    = 17'd20000;
   localparam logic [9:0]  STEP_RST    = 10'd10;
   localparam logic [2:0]  REVERSE_RST = 3'd2;

   localparam logic signed [7:0] SPEED_MAX = 8'sd100;
   // floor(x / 100) for x below 2^22
   localparam int          PCT_SHIFT = 29;
   localparam logic [22:0] PCT_RECIP = 23'd5368710;

   function automatic logic [14:0] clamp_w(input logic signed [17:0] v,
                                           input logic [14:0] lo,
                                           input logic [14:0] hi);
      logic [14:0] res;
      if (v < $signed({3'b0, lo})) begin
         res = lo;
      end else if (v > $signed({3'b0, hi})) begin
         res = hi;
      end else begin
         res = v[14:0];
      end
      return res;
   endfunction

   function automatic logic [15:0] slew_one(input logic [15:0] tgt,
                                            input logic [15:0] cur,
                                            input logic [9:0] step);
      logic signed [16:0] d;
      logic [16:0]        ad;
      logic [15:0]        res;
      d  = $signed({1'b0, tgt}) - $signed({1'b0, cur});
      ad = d[16] ? 17'(-d) : 17'(d);
      if (ad <= {7'b0, step}) begin
         res = tgt;
      end else if (!d[16]) begin
         res = cur + {6'b0, step};
      end else begin
         res = cur - {6'b0, step};
      end
      return res;
   endfunction

   // configuration
   logic [14:0] min_ff;
   logic [14:0] neutral_ff;
   logic [14:0] max_ff;
   logic [16:0] wrap_ff;
   logic [9:0]  step_ff;
   logic [2:0]  reverse_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff     <= MIN_RST;
         neutral_ff <= NEUTRAL_RST;
         max_ff     <= MAX_RST;
         wrap_ff    <= WRAP_RST;
         step_ff    <= STEP_RST;
         reverse_ff <= REVERSE_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_MIN:     min_ff     <= csr_pwdata[14:0];
            CSR_NEUTRAL: neutral_ff <= csr_pwdata[14:0];
            CSR_MAX:     max_ff     <= csr_pwdata[14:0];
            CSR_WRAP:    wrap_ff    <= csr_pwdata[16:0];
            CSR_STEP:    step_ff    <= csr_pwdata[9:0];
            CSR_REVERSE: reverse_ff <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_MIN:     csr_prdata = {17'b0, min_ff};
         CSR_NEUTRAL: csr_prdata = {17'b0, neutral_ff};
         CSR_MAX:     csr_prdata = {17'b0, max_ff};
         CSR_WRAP:    csr_prdata = {15'b0, wrap_ff};
         CSR_STEP:    csr_prdata = {22'b0, step_ff};
         CSR_REVERSE: csr_prdata = {29'b0, reverse_ff};
         default:     csr_prdata = 32'b0;
      endcase
   end

   // pipeline control
   logic s1_v_ff;
   logic s2_v_ff;
   logic lvl_stall;
   logic adv1;
   logic adv2;
   logic accept;
   logic step;

   assign adv2      = !s2_v_ff || !lvl_stall;
   assign adv1      = !s1_v_ff || adv2;
   assign req_stall = !adv1;
   assign accept    = req_valid && adv1;
   assign step      = s1_v_ff && adv2;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         if (adv1) begin
            s1_v_ff <= req_valid;
         end
         if (adv2) begin
            s2_v_ff <= s1_v_ff;
         end
      end
   end

   // input stage: clamp speed, apply reversal, multiply by span
   logic signed [7:0]  spd_clip;
   logic signed [7:0]  spd_eff;
   logic signed [15:0] diff_sel;
   logic [3:0]         rev_bits;
   logic signed [23:0] s1_prod_in;
   logic signed [23:0] s1_prod_ff;
   logic               s1_zero_ff;
   req_item_type       s1_item_ff;

   always_comb begin
      if (req_item.speed > SPEED_MAX) begin
         spd_clip = SPEED_MAX;
      end else if (req_item.speed < -SPEED_MAX) begin
         spd_clip = -SPEED_MAX;
      end else begin
         spd_clip = req_item.speed;
      end
      rev_bits = {1'b0, reverse_ff};
      spd_eff  = rev_bits[req_item.channel] ? -spd_clip : spd_clip;
      if (spd_eff > 0) begin
         diff_sel = $signed({1'b0, max_ff}) - $signed({1'b0, neutral_ff});
      end else begin
         diff_sel = $signed({1'b0, neutral_ff}) - $signed({1'b0, min_ff});
      end
      s1_prod_in = spd_eff * diff_sel;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_item;
         s1_prod_ff <= s1_prod_in;
         s1_zero_ff <= (req_item.speed == 8'sd0);
      end
   end

   // state update stage
   logic [NUM_CH-1:0][15:0] tgt_ff;
   logic [NUM_CH-1:0][15:0] tgt_in;
   logic [NUM_CH-1:0][15:0] cur_ff;
   logic [NUM_CH-1:0][15:0] cur_in;
   logic [NUM_CH-1:0][15:0] safe_w;
   logic                    run_ff;
   logic                    run_in;
   logic                    ok_in;
   logic                    prod_neg;
   logic [21:0]             prod_mag;
   logic [44:0]             pct_full;
   logic [15:0]             pct_quot;
   logic signed [17:0]      map_sum;
   logic [14:0]             map_w;
   logic signed [17:0]      req_val;
   logic [14:0]             pulse_w;
   logic                    ch_ok;
   snap_type                s2_snap_ff;
   snap_type                s2_snap_in;

   always_comb begin
      prod_neg = s1_prod_ff[23];
      prod_mag = prod_neg ? 22'(-s1_prod_ff) : 22'(s1_prod_ff);
      pct_full = prod_mag * PCT_RECIP;
      pct_quot = pct_full[PCT_SHIFT +: 16];
      map_sum  = $signed({3'b0, neutral_ff})
               + (prod_neg ? -$signed({2'b0, pct_quot}) : $signed({2'b0, pct_quot}));
      map_w    = s1_zero_ff ? neutral_ff : clamp_w(map_sum, min_ff, max_ff);
      if (s1_item_ff.req_type == REQ_SPEED) begin
         req_val = $signed({3'b0, map_w});
      end else begin
         req_val = $signed({2'b0, s1_item_ff.pulse_width});
      end
      if (s1_item_ff.channel == CH_WEAPON && (s1_item_ff.failsafe || !s1_item_ff.armed)) begin
         req_val = $signed({3'b0, min_ff});
      end
      pulse_w = clamp_w(req_val, min_ff, max_ff);
      ch_ok   = (s1_item_ff.channel != CH_NONE);

      for (int c = 0; c < NUM_CH; c++) begin
         safe_w[c] = (2'(c) == CH_WEAPON) ? {1'b0, min_ff} : {1'b0, neutral_ff};
      end

      tgt_in = tgt_ff;
      cur_in = cur_ff;
      run_in = run_ff;
      ok_in  = 1'b0;
      case (s1_item_ff.req_type)
         REQ_TICK: begin
            if (run_ff) begin
               for (int c = 0; c < NUM_CH; c++) begin
                  cur_in[c] = slew_one(tgt_ff[c], cur_ff[c], step_ff);
               end
               ok_in = 1'b1;
            end
         end
         REQ_SPEED, REQ_PULSE: begin
            if (run_ff && ch_ok) begin
               for (int c = 0; c < NUM_CH; c++) begin
                  if (s1_item_ff.channel == 2'(c)) begin
                     tgt_in[c] = {1'b0, pulse_w};
                  end
               end
               ok_in = 1'b1;
            end
         end
         REQ_STOP: begin
            if (run_ff) begin
               tgt_in = safe_w;
               cur_in = safe_w;
               ok_in  = 1'b1;
            end
         end
         REQ_ESTOP: begin
            if (run_ff) begin
               tgt_in = safe_w;
               cur_in = safe_w;
            end
            run_in = 1'b0;
            ok_in  = 1'b1;
         end
         REQ_INIT: begin
            if (!run_ff) begin
               tgt_in = safe_w;
               cur_in = safe_w;
               run_in = 1'b1;
            end
            ok_in = 1'b1;
         end
         default: ;
      endcase

      s2_snap_in.ok      = ok_in;
      s2_snap_in.enabled = run_in;
      s2_snap_in.width   = cur_in;
      for (int c = 0; c < NUM_CH; c++) begin
         s2_snap_in.pulse[c] = run_in ? cur_in[c] : {1'b0, neutral_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b1;
         for (int c = 0; c < NUM_CH; c++) begin
            tgt_ff[c] <= (2'(c) == CH_WEAPON) ? {1'b0, MIN_RST} : {1'b0, NEUTRAL_RST};
            cur_ff[c] <= (2'(c) == CH_WEAPON) ? {1'b0, MIN_RST} : {1'b0, NEUTRAL_RST};
         end
      end else if (step) begin
         run_ff <= run_in;
         tgt_ff <= tgt_in;
         cur_ff <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         s2_snap_ff <= s2_snap_in;
      end
   end

   esc_level_pipe u_level (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_v_ff),
      .in_stall  (lvl_stall),
      .in_snap   (s2_snap_ff),
      .wrap      (wrap_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

FILE: sv/esc_checker.sv
module esc_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input esc_pkg::rsp_item_type rsp_item
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_item))
      else $error("stalled result item changed");

   a_disabled_neutral: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.enabled |->
         rsp_item.left_pulse == rsp_item.right_pulse &&
         rsp_item.right_pulse == rsp_item.weapon_pulse)
      else $error("disabled result does not report one neutral width");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result item present right after reset");

   a_ready_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !req_stall)
      else $error("input stalled right after reset");

endmodule

bind esc_pulse_slew_controller esc_checker u_esc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);
